// ===== src/rsc_pkg.sv =====
package rsc_pkg;

  // Field widths of the request and result transactions
  localparam int unsigned IdxW  = 3;
  localparam int unsigned MaskW = 8;

  // Default number of basic relations
  localparam int unsigned BaseDefault = 8;

  typedef enum logic {
    ReqWrite   = 1'b0,
    ReqCompose = 1'b1
  } req_kind_e;

  // Table write command from the request stage to the table
  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [MaskW-1:0] mask;
  } tbl_wr_t;

endpackage

// ===== src/rsc_in_if.sv =====
interface rsc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [rsc_pkg::IdxW-1:0]  row_index;
  logic [rsc_pkg::IdxW-1:0]  col_index;
  logic [rsc_pkg::MaskW-1:0] entry_mask;
  logic [rsc_pkg::MaskW-1:0] rel_a;
  logic [rsc_pkg::MaskW-1:0] rel_b;

  modport source (
    output valid, req_type, row_index, col_index, entry_mask, rel_a, rel_b,
    input  ready
  );

  modport sink (
    input  valid, req_type, row_index, col_index, entry_mask, rel_a, rel_b,
    output ready
  );
endinterface

// ===== src/rsc_out_if.sv =====
interface rsc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rsc_pkg::MaskW-1:0] result_mask;

  modport source (
    output valid, result_mask,
    input  ready
  );

  modport sink (
    input  valid, result_mask,
    output ready
  );
endinterface

// ===== src/rsc_table.sv =====
module rsc_table #(
  parameter int unsigned BASE = rsc_pkg::BaseDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rsc_pkg::tbl_wr_t          wr_i,
  input  logic [rsc_pkg::MaskW-1:0] rel_a_i,
  input  logic [rsc_pkg::MaskW-1:0] rel_b_i,
  output logic [rsc_pkg::MaskW-1:0] result_o
);

  // Only basic relations reachable through the 8-bit masks are stored
  localparam int unsigned Use = (BASE < rsc_pkg::MaskW) ? BASE : rsc_pkg::MaskW;

  logic [Use-1:0] cell_q [Use][Use];
  logic [Use-1:0] acc;

  for (genvar r = 0; r < Use; r++) begin : g_row
    for (genvar c = 0; c < Use; c++) begin : g_col
      logic hit;
      assign hit = wr_i.en && (wr_i.row == rsc_pkg::IdxW'(r))
                           && (wr_i.col == rsc_pkg::IdxW'(c));

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cell_q[r][c] <= '0;
        end else if (hit) begin
          cell_q[r][c] <= wr_i.mask[Use-1:0];
        end
      end
    end
  end

  // OR of every entry whose row is set in rel_a and whose column is set in rel_b
  always_comb begin
    acc = '0;
    for (int r = 0; r < Use; r++) begin
      for (int c = 0; c < Use; c++) begin
        if (rel_a_i[r] && rel_b_i[c]) begin
          acc = acc | cell_q[r][c];
        end
      end
    end
  end

  assign result_o = rsc_pkg::MaskW'(acc);

endmodule

// ===== src/relation_set_composition.sv =====
// Channel  Port   Dir  Payload
// request  in_i   in   req_type, row_index, col_index, entry_mask, rel_a, rel_b
// result   out_o  out  result_mask (one per compose transaction, none per write)
//
// One request transaction is taken every cycle unless a compose waits behind
// a stalled result. A transaction is held in the request register, then the
// composition table is read or written and a compose result lands in the
// result register. The composition is one AND-OR over the table cells, read
// in parallel. Reset clears the table to all zeros and drops both pipeline
// registers. A stalled result holds the result register; a compose behind it
// waits in the request register, while a write passes through regardless.
module relation_set_composition #(
  parameter int unsigned BASE = rsc_pkg::BaseDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rsc_in_if.sink   in_i,
  rsc_out_if.source out_o
);

  // Request register
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_type_q;
  logic [rsc_pkg::IdxW-1:0]  s1_row_q;
  logic [rsc_pkg::IdxW-1:0]  s1_col_q;
  logic [rsc_pkg::MaskW-1:0] s1_entry_q;
  logic [rsc_pkg::MaskW-1:0] s1_a_q;
  logic [rsc_pkg::MaskW-1:0] s1_b_q;

  // Result register
  logic                      out_valid_q, out_valid_d;
  logic [rsc_pkg::MaskW-1:0] out_mask_q, out_mask_d;

  logic                      out_free;
  logic                      s1_is_write;
  logic                      s1_go;
  logic                      in_fire;
  logic [rsc_pkg::MaskW-1:0] comp_mask;
  rsc_pkg::tbl_wr_t          tbl_wr;

  // A write needs no result slot; a compose needs the result register free
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_is_write = (s1_type_q == rsc_pkg::ReqWrite);
  assign s1_go       = s1_valid_q && (s1_is_write || out_free);
  assign in_i.ready  = !s1_valid_q || s1_go;
  assign in_fire     = in_i.valid && in_i.ready;

  always_comb begin
    tbl_wr.en   = s1_go && s1_is_write;
    tbl_wr.row  = s1_row_q;
    tbl_wr.col  = s1_col_q;
    tbl_wr.mask = s1_entry_q;
  end

  rsc_table #(
    .BASE (BASE)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rel_a_i  (s1_a_q),
    .rel_b_i  (s1_b_q),
    .result_o (comp_mask)
  );

  always_comb begin
    // Advance the request register
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end

    // Load a compose result, or drop the one just taken
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    if (s1_go && !s1_is_write) begin
      out_valid_d = 1'b1;
      out_mask_d  = comp_mask;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_type_q  <= in_i.req_type;
      s1_row_q   <= in_i.row_index;
      s1_col_q   <= in_i.col_index;
      s1_entry_q <= in_i.entry_mask;
      s1_a_q     <= in_i.rel_a;
      s1_b_q     <= in_i.rel_b;
    end
    out_mask_q <= out_mask_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_mask = out_mask_q;

endmodule
